// File: rtl/dcfl_pkg.sv
// ----------------------------------------------------------------------------
// dcfl_pkg
// Shared constants, codes and control types for the DC blocker / limiter.
// ----------------------------------------------------------------------------
package dcfl_pkg;

    localparam int SAMPLE_WIDTH_DEF = 24;
    localparam int CHANNEL_COUNT    = 2;
    localparam int CH_IDX_W         = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    localparam int COEFF_W   = 16;
    localparam int THRESH_W  = 22;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = THRESH_W;

    // feedback coefficient is unsigned Q0.16, product rounded half up
    localparam int FRAC_SHIFT = 16;
    localparam int ROUND_HALF = 32768;

    localparam logic [COEFF_W-1:0]  COEFF_RST  = 16'd65405;
    localparam logic [THRESH_W-1:0] THRESH_RST = 22'd655360;

    localparam logic [MODE_W-1:0] MODE_TRUNC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_MIRROR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PASS   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DC_COEFF        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_MODE      = 2'd2;

    typedef logic [CH_IDX_W-1:0] t_chan;

    typedef struct packed {
        logic  mul_en;
        logic  sum_en;
        t_chan ch;
    } t_filt_ctrl;

    typedef struct packed {
        logic done;
        logic odd;
    } t_div_status;

endpackage

// File: rtl/dc_block_and_fold_limiter.sv
// ----------------------------------------------------------------------------
// dc_block_and_fold_limiter
// Stereo DC blocker followed by a threshold limiter (truncate, mirror fold
// or pass through), with a report of the pre-limit sample when over.
// ----------------------------------------------------------------------------
// Usage:
//   Input words carry one stereo frame (left/right, signed Q3.20). A word is
//   taken when i_in_valid is high and o_in_stall is low; o_in_stall stays
//   high while a frame is being worked on.
//   Channels run one after the other through a shared multiplier and adder.
//   Per channel: multiply, add/saturate, magnitude, compare, and in mirror
//   mode, when the sample is over a nonzero threshold, a bit-serial divide
//   plus a fold step.
//   The result word sits in an output register; the next frame is accepted
//   while it waits. If the receiver holds i_out_stall high, the finished
//   frame waits in the core until the output register frees up.
//   Config writes (i_cfg_valid, always ready) are meant for idle periods.
//   Synchronous reset clears the filter history, restores the register
//   defaults and empties the output register.
// ----------------------------------------------------------------------------
module dc_block_and_fold_limiter #(
    parameter int SAMPLE_WIDTH = dcfl_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,

    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_left_sample,
    input  logic signed [SAMPLE_WIDTH-1:0]        i_right_sample,

    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic signed [SAMPLE_WIDTH-1:0]        o_left_out,
    output logic signed [SAMPLE_WIDTH-1:0]        o_right_out,
    output logic signed [SAMPLE_WIDTH-1:0]        o_left_over,
    output logic signed [SAMPLE_WIDTH-1:0]        o_right_over,

    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [dcfl_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [dcfl_pkg::CFG_DATA_W-1:0]       i_cfg_data
);
    import dcfl_pkg::*;

    localparam int W      = SAMPLE_WIDTH;
    localparam int MAG_W  = (W > THRESH_W) ? W : THRESH_W + 1;
    localparam int SPAN_W = THRESH_W + 1;
    localparam t_chan CH_LAST = CH_IDX_W'(CHANNEL_COUNT - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_MAG,
        S_LIM,
        S_DIV,
        S_FOLD,
        S_DONE
    } t_state;

    // configuration
    logic [COEFF_W-1:0]  r_coeff;
    logic [THRESH_W-1:0] r_thresh;
    logic [MODE_W-1:0]   r_mode;

    // sequencer and datapath registers
    t_state              r_state;
    t_chan               r_ch;
    logic signed [W-1:0] r_x   [CHANNEL_COUNT];
    logic [MAG_W-1:0]    r_mag;
    logic                r_neg;
    logic signed [W-1:0] r_res [CHANNEL_COUNT];
    logic signed [W-1:0] r_ovr [CHANNEL_COUNT];
    logic                r_out_valid;
    logic signed [W-1:0] r_out_res [CHANNEL_COUNT];
    logic signed [W-1:0] r_out_ovr [CHANNEL_COUNT];

    t_filt_ctrl          filt_ctrl;
    logic signed [W-1:0] y;
    t_div_status         div_status;
    logic [SPAN_W-1:0]   div_rem;
    logic                div_start;

    logic signed [W:0]       y_ext;
    logic [MAG_W-1:0]        t_mag;
    logic                    beyond;
    logic [MAG_W-1:0]        excess;
    logic signed [MAG_W:0]   t_s;
    logic signed [MAG_W:0]   trunc_val;
    logic signed [MAG_W:0]   fold_mag;
    logic signed [MAG_W:0]   fold_val;
    logic                    in_acc;
    logic                    out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coeff  <= COEFF_RST;
            r_thresh <= THRESH_RST;
            r_mode   <= MODE_TRUNC;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DC_COEFF:        r_coeff  <= i_cfg_data[COEFF_W-1:0];
                CFG_LIMIT_THRESHOLD: r_thresh <= i_cfg_data[THRESH_W-1:0];
                CFG_LIMIT_MODE:      r_mode   <= i_cfg_data[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    assign filt_ctrl.mul_en = (r_state == S_MUL);
    assign filt_ctrl.sum_en = (r_state == S_SUM);
    assign filt_ctrl.ch     = r_ch;

    dcfl_filter #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_filter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (filt_ctrl),
        .i_coeff (r_coeff),
        .i_x     (r_x[r_ch]),
        .o_y     (y)
    );

    // limiter arithmetic
    assign y_ext     = (W + 1)'(y);
    assign t_mag     = MAG_W'(r_thresh);
    assign beyond    = r_mag > t_mag;
    assign excess    = r_mag - t_mag;
    assign t_s       = $signed((MAG_W + 1)'(r_thresh));
    assign trunc_val = r_neg ? -t_s : t_s;
    assign fold_mag  = div_status.odd ? ($signed((MAG_W + 1)'(div_rem)) - t_s)
                                      : (t_s - $signed((MAG_W + 1)'(div_rem)));
    assign fold_val  = r_neg ? -fold_mag : fold_mag;

    assign div_start = (r_state == S_LIM) && beyond && (r_mode == MODE_MIRROR)
                       && (r_thresh != '0);

    dcfl_fold_div #(
        .NUM_W (MAG_W),
        .DEN_W (SPAN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (excess),
        .i_divisor  ({r_thresh, 1'b0}),
        .o_status   (div_status),
        .o_rem      (div_rem)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ch        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_x[0]  <= i_left_sample;
                        r_x[1]  <= i_right_sample;
                        r_ch    <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: r_state <= S_SUM;
                S_SUM: r_state <= S_MAG;
                S_MAG: begin
                    r_neg   <= y[W-1];
                    r_mag   <= MAG_W'(y[W-1] ? -y_ext : y_ext);
                    r_state <= S_LIM;
                end
                S_LIM: begin
                    r_ovr[r_ch] <= beyond ? y : '0;
                    if (div_start) begin
                        r_state <= S_DIV;
                    end else begin
                        if (!beyond) begin
                            r_res[r_ch] <= y;
                        end else begin
                            case (r_mode)
                                MODE_TRUNC:  r_res[r_ch] <= trunc_val[W-1:0];
                                MODE_MIRROR: r_res[r_ch] <= '0;  // zero threshold
                                default:     r_res[r_ch] <= y;
                            endcase
                        end
                        if (r_ch == CH_LAST) begin
                            r_state <= S_DONE;
                        end else begin
                            r_ch    <= r_ch + CH_IDX_W'(1);
                            r_state <= S_MUL;
                        end
                    end
                end
                S_DIV: begin
                    if (div_status.done) begin
                        r_state <= S_FOLD;
                    end
                end
                S_FOLD: begin
                    r_res[r_ch] <= fold_val[W-1:0];
                    if (r_ch == CH_LAST) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ch    <= r_ch + CH_IDX_W'(1);
                        r_state <= S_MUL;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_res   <= r_res;
                        r_out_ovr   <= r_ovr;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_left_out   = r_out_res[0];
    assign o_right_out  = r_out_res[1];
    assign o_left_over  = r_out_ovr[0];
    assign o_right_over = r_out_ovr[1];

endmodule

// File: rtl/dcfl_filter.sv
// ----------------------------------------------------------------------------
// dcfl_filter
// DC blocker datapath: one feedback multiply, then add and saturate, with
// per-channel history registers. Channels are processed one at a time.
// ----------------------------------------------------------------------------
module dcfl_filter #(
    parameter int SAMPLE_WIDTH = dcfl_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  dcfl_pkg::t_filt_ctrl                 i_ctrl,
    input  logic [dcfl_pkg::COEFF_W-1:0]         i_coeff,
    input  logic signed [SAMPLE_WIDTH-1:0]       i_x,
    output logic signed [SAMPLE_WIDTH-1:0]       o_y
);
    import dcfl_pkg::*;

    localparam int W     = SAMPLE_WIDTH;
    localparam int PW    = W + COEFF_W + 1;
    localparam int FW    = PW - FRAC_SHIFT;
    localparam int SW    = W + 3;
    localparam logic signed [SW-1:0] SAT_HI = SW'((64'sd1 <<< (W - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);

    logic signed [W-1:0]  r_prev_in  [CHANNEL_COUNT];
    logic signed [W-1:0]  r_prev_out [CHANNEL_COUNT];
    logic signed [PW-1:0] r_prod;
    logic signed [W-1:0]  r_y;

    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] rounded;
    logic signed [FW-1:0] fb;
    logic signed [SW-1:0] sum;
    logic signed [W-1:0]  n_y;

    assign prod    = $signed({1'b0, i_coeff}) * r_prev_out[i_ctrl.ch];
    assign rounded = r_prod + PW'(ROUND_HALF);
    assign fb      = rounded[PW-1:FRAC_SHIFT];   // floor shift
    assign sum     = SW'(i_x) - SW'(r_prev_in[i_ctrl.ch]) + SW'(fb);

    always_comb begin
        if (sum > SAT_HI) begin
            n_y = SAT_HI[W-1:0];
        end else if (sum < SAT_LO) begin
            n_y = SAT_LO[W-1:0];
        end else begin
            n_y = sum[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CHANNEL_COUNT; c++) begin
                r_prev_in[c]  <= '0;
                r_prev_out[c] <= '0;
            end
        end else if (i_ctrl.sum_en) begin
            r_prev_in[i_ctrl.ch]  <= i_x;
            r_prev_out[i_ctrl.ch] <= n_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= prod;
        end
        if (i_ctrl.sum_en) begin
            r_y <= n_y;
        end
    end

    assign o_y = r_y;

endmodule

// File: rtl/dcfl_fold_div.sv
// ----------------------------------------------------------------------------
// dcfl_fold_div
// Restoring divider, one quotient bit per cycle. Returns the remainder and
// the quotient parity, which is all the fold limiter needs.
// ----------------------------------------------------------------------------
module dcfl_fold_div #(
    parameter int NUM_W = 24,
    parameter int DEN_W = 23
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [NUM_W-1:0]           i_dividend,
    input  logic [DEN_W-1:0]           i_divisor,
    output dcfl_pkg::t_div_status      o_status,
    output logic [DEN_W-1:0]           o_rem
);
    import dcfl_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [DEN_W-1:0] r_rem;
    logic             r_odd;

    logic [DEN_W:0]   trial;
    logic             ge;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign ge    = trial >= {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
                r_num  <= i_dividend;
                r_rem  <= '0;
            end else if (r_busy) begin
                r_rem <= ge ? DEN_W'(trial - {1'b0, i_divisor}) : DEN_W'(trial);
                r_odd <= ge;
                r_num <= {r_num[NUM_W-2:0], 1'b0};
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_status.done = r_done;
    assign o_status.odd  = r_odd;
    assign o_rem         = r_rem;

endmodule

// File: rtl/dcfl_checker.sv
// ----------------------------------------------------------------------------
// dcfl_checker
// Port-level checks for the DC blocker / limiter, bound to the top level.
// ----------------------------------------------------------------------------
module dcfl_checker #(
    parameter int SAMPLE_WIDTH = dcfl_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    input  logic                                  o_in_stall,
    input  logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    input  logic signed [SAMPLE_WIDTH-1:0]        o_left_out,
    input  logic signed [SAMPLE_WIDTH-1:0]        o_right_out,
    input  logic signed [SAMPLE_WIDTH-1:0]        o_left_over,
    input  logic signed [SAMPLE_WIDTH-1:0]        o_right_over
);

    // a frame in work blocks the next one
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input accepted while a frame was in work");

    // a result only appears after the core was busy
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result word without preceding work");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_left_out)
            && $stable(o_right_out) && $stable(o_left_over) && $stable(o_right_over)))
        else $error("stalled result word changed");

endmodule

bind dc_block_and_fold_limiter dcfl_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_dcfl_checker (.*);
